// ----- design/rtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared types, constants and helpers for the run-length texture row decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

   localparam int MAX_ROW_WIDTH = 256;
   localparam int ROW_WIDTH_W   = $clog2(MAX_ROW_WIDTH + 1);
   localparam int IMG_WIDTH_W   = 9;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_ROW   = 1'b1;

   localparam logic [15:0] WORD_ZERO = 16'h0000;

   typedef struct packed {
      logic       command;
      logic       row_compressed;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  pixel_value;
      logic [15:0] repeat_count;
      logic        row_end;
      logic        status;
   } rsp_type;

   // classified item as held in the queue between front and back
   typedef struct packed {
      logic       is_start;
      logic       compressed;
      logic [7:0] data_byte;
   } entry_type;

   function automatic logic [ROW_WIDTH_W-1:0] bound_width(input logic [15:0] w);
      if (w > 16'(MAX_ROW_WIDTH)) begin
         return ROW_WIDTH_W'(MAX_ROW_WIDTH);
      end else begin
         return w[ROW_WIDTH_W-1:0];
      end
   endfunction

endpackage

// ----- design/rtd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_front
// Accepts request items, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module rtd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rtd_pkg::req_type   req_item,
   output logic               q_valid,
   output rtd_pkg::entry_type q_entry,
   input  logic               q_pop
);
   import rtd_pkg::*;

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   entry_type              new_entry;

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entries_ff[rd_ptr_ff];

   always_comb begin
      new_entry.is_start   = (req_item.command == CMD_START);
      new_entry.compressed = req_item.row_compressed;
      new_entry.data_byte  = req_item.data_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ----- design/rtd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_back
// Row parser: walks raw, width, count, literal and run bytes and registers results.
// ----------------------------------------------------------------------------
module rtd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rtd_pkg::IMG_WIDTH_W-1:0] image_width,
   input  logic                            q_valid,
   input  rtd_pkg::entry_type              q_entry,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rtd_pkg::rsp_type                rsp_item
);
   import rtd_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_RAW  = 3'd1;
   localparam logic [2:0] PH_WLO  = 3'd2;
   localparam logic [2:0] PH_WHI  = 3'd3;
   localparam logic [2:0] PH_CLO  = 3'd4;
   localparam logic [2:0] PH_CHI  = 3'd5;
   localparam logic [2:0] PH_LIT  = 3'd6;
   localparam logic [2:0] PH_RUN  = 3'd7;

   logic [2:0]             phase_ff, phase_in;
   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   logic [16:0]            pixels_ff, pixels_in;
   logic [15:0]            group_ff, group_in;
   logic [7:0]             low_ff, low_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   step;
   logic                   has_result;
   rsp_type                result;
   logic [15:0]            word;
   logic [ROW_WIDTH_W-1:0] bounded;
   logic [16:0]            pix_next;
   logic [15:0]            grp_next;

   assign step      = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop     = step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign word      = {q_entry.data_byte, low_ff};

   always_comb begin
      phase_in     = phase_ff;
      row_width_in = row_width_ff;
      pixels_in    = pixels_ff;
      group_in     = group_ff;
      low_in       = low_ff;
      has_result   = 1'b0;
      result       = '0;
      bounded      = '0;
      pix_next     = pixels_ff + 17'd1;
      grp_next     = group_ff - 16'd1;
      if (step) begin
         if (q_entry.is_start) begin
            pixels_in = '0;
            group_in  = '0;
            low_in    = '0;
            if (q_entry.compressed) begin
               row_width_in = '0;
               phase_in     = PH_WLO;
            end else begin
               bounded      = bound_width(16'(image_width));
               row_width_in = bounded;
               if (bounded == '0) begin
                  // empty raw row: row-end marker
                  phase_in       = PH_IDLE;
                  has_result     = 1'b1;
                  result.row_end = 1'b1;
               end else begin
                  phase_in = PH_RAW;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_RAW: begin
                  pixels_in           = pix_next;
                  has_result          = 1'b1;
                  result.pixel_value  = q_entry.data_byte;
                  result.repeat_count = 16'd1;
                  if (pix_next >= 17'(row_width_ff)) begin
                     result.row_end = 1'b1;
                     phase_in       = PH_IDLE;
                  end
               end
               PH_WLO: begin
                  low_in   = q_entry.data_byte;
                  phase_in = PH_WHI;
               end
               PH_WHI: begin
                  if (word == WORD_ZERO || word[15]) begin
                     phase_in       = PH_IDLE;
                     has_result     = 1'b1;
                     result.row_end = 1'b1;
                  end else begin
                     row_width_in = bound_width(word);
                     phase_in     = PH_CLO;
                  end
               end
               PH_CLO: begin
                  low_in   = q_entry.data_byte;
                  phase_in = PH_CHI;
               end
               PH_CHI: begin
                  if (word != WORD_ZERO && !word[15]) begin
                     group_in = word;
                     phase_in = PH_LIT;
                  end else begin
                     // run length is minus the count, zero stays zero
                     group_in = WORD_ZERO - word;
                     phase_in = PH_RUN;
                  end
               end
               PH_LIT: begin
                  group_in            = grp_next;
                  pixels_in           = pix_next;
                  has_result          = 1'b1;
                  result.pixel_value  = q_entry.data_byte;
                  result.repeat_count = 16'd1;
                  if (grp_next == WORD_ZERO) begin
                     if (pix_next >= 17'(row_width_ff)) begin
                        result.row_end = 1'b1;
                        phase_in       = PH_IDLE;
                     end else begin
                        phase_in = PH_CLO;
                     end
                  end
               end
               PH_RUN: begin
                  pix_next            = pixels_ff + 17'(group_ff);
                  pixels_in           = pix_next;
                  group_in            = '0;
                  has_result          = 1'b1;
                  result.pixel_value  = q_entry.data_byte;
                  result.repeat_count = group_ff;
                  if (pix_next >= 17'(row_width_ff)) begin
                     result.row_end = 1'b1;
                     phase_in       = PH_IDLE;
                  end else begin
                     phase_in = PH_CLO;
                  end
               end
               default: begin
                  // data item with no row open
                  has_result    = 1'b1;
                  result.status = STATUS_NO_ROW;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = has_result;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         row_width_ff <= '0;
         pixels_ff    <= '0;
         group_ff     <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         row_width_ff <= row_width_in;
         pixels_ff    <= pixels_in;
         group_ff     <= group_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- design/rle_texture_row_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_texture_row_decoder_core
// Decodes raw or run-length coded texture rows into pixel/repeat results.
// ----------------------------------------------------------------------------
// usage:
//   req channel carries start items (command 0, row_compressed picks coding)
//   and stream bytes (command 1); rsp channel returns at most one result per
//   item: a pixel byte with its repeat count, row_end on the last one
//   csr port writes image_width (raw row length), which is 64 after reset
// flow: an accepted item is written into the queue, then parsed once the
//   parser can step, and its result is registered before it is offered
// throughput: one item per cycle while rsp_ready is high; the parser handles
//   one byte per cycle and a two-entry queue sits between input and parser
// stall: while a registered result waits and rsp_ready is low, it holds,
//   the parser stops and the queue fills; req_ready drops once it is full
// reset: queue empty, no row open, no result pending
// ----------------------------------------------------------------------------
module rle_texture_row_decoder_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rtd_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rtd_pkg::rsp_type                rsp_item,
   input  logic                            csr_wr_en,
   input  logic [rtd_pkg::IMG_WIDTH_W-1:0] csr_wr_data
);
   import rtd_pkg::*;

   localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RESET = IMG_WIDTH_W'(64);

   logic [IMG_WIDTH_W-1:0] image_width_ff, image_width_in;
   logic                   q_valid;
   logic                   q_pop;
   entry_type              q_entry;

   assign image_width_in = csr_wr_en ? csr_wr_data : image_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_RESET;
      end else begin
         image_width_ff <= image_width_in;
      end
   end

   rtd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   rtd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .image_width (image_width_ff),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule
